// ----- rtl/tape_machine_executor_macros.svh -----
// Assertion shorthands used by the checker file tme_checker.sv.
`ifndef TAPE_MACHINE_EXECUTOR_MACROS_SVH
`define TAPE_MACHINE_EXECUTOR_MACROS_SVH

// Same-cycle implication, idle during reset.
`define TME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset.
`define TME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tme_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tme_pkg;

  localparam int CELL_W         = 8;
  localparam int VAL_W          = 15;
  localparam int ACT_W          = 4;
  localparam int TAPE_CELLS_DEF = 32768;

  typedef enum logic [ACT_W-1:0] {
    ACT_RIGHT      = 4'd0,
    ACT_LEFT       = 4'd1,
    ACT_HOME       = 4'd2,
    ACT_READ       = 4'd3,
    ACT_WRITE      = 4'd4,
    ACT_COPYLEFT   = 4'd5,
    ACT_CLEAR      = 4'd6,
    ACT_SAVE       = 4'd7,
    ACT_LOAD       = 4'd8,
    ACT_MUL        = 4'd9,
    ACT_DIV        = 4'd10,
    ACT_INC        = 4'd11,
    ACT_DEC        = 4'd12,
    ACT_TEST       = 4'd13,
    ACT_PRINTVAR   = 4'd14,
    ACT_VARFROMPTR = 4'd15
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LEFT,
    S_CUR,
    S_DIV,
    S_MOVE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/tme_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/tme_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tme_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [tme_pkg::CELL_W-1:0] dividend,
  input  wire logic [tme_pkg::CELL_W-1:0] divisor,
  output logic                           done,
  output logic      [tme_pkg::CELL_W-1:0] quotient
);

  import tme_pkg::*;

  localparam int CW = $clog2(CELL_W);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [CELL_W-1:0] quo;
  logic [CELL_W-1:0] rem;
  logic [CELL_W-1:0] dvs;
  logic [CELL_W:0]   shifted;
  logic [CELL_W:0]   trial;

  assign shifted  = {rem, quo[CELL_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(CELL_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(CELL_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[CELL_W]) begin
        rem <= trial[CELL_W-1:0];
        quo <= {quo[CELL_W-2:0], 1'b1};
      end else begin
        rem <= shifted[CELL_W-1:0];
        quo <= {quo[CELL_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tape_machine_executor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Tape machine executor: runs one decoded tape-language instruction per
// item and returns one result item for it (output value, out_valid,
// cell_is_zero, div_error). The byte tape sits in a single synchronous RAM
// with a registered read; after reset a clearing pass writes zero into
// every cell, one cell per cycle, so in_ready stays low until it is done.
// Each item then reads the left neighbor and the current cell one after
// the other, computes, and writes the cell back; pointer moves add S_MOVE
// (the new cell must be read for cell_is_zero), and a divide by a nonzero
// left cell waits in S_DIV for the 8-bit restoring divider. The result
// sits in an output register, so a new item is taken while the previous
// result waits; only the final write-back stalls until that register frees.
module tape_machine_executor #(
  parameter int TAPE_CELLS = tme_pkg::TAPE_CELLS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [tme_pkg::ACT_W-1:0]  action,
  input  wire logic [tme_pkg::CELL_W-1:0] read_value,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output logic      [tme_pkg::VAL_W-1:0]  out_value,
  output logic                            out_valid,
  output logic                            cell_is_zero,
  output logic                            div_error
);

  import tme_pkg::*;

  localparam int PW = $clog2(TAPE_CELLS);

  state_t            state, state_next;
  action_t           act_q;
  logic [CELL_W-1:0] rd_q;
  logic [CELL_W-1:0] lft_q;
  logic [CELL_W-1:0] cur_q;
  logic [CELL_W-1:0] cell_new_q;
  logic              zero_q;
  logic              derr_q;
  logic [PW-1:0]     ptr;
  logic [VAL_W-1:0]  svar;
  logic [PW-1:0]     clr_addr;

  // tape port
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [PW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // pointer neighbors, both wrap at the tape ends
  logic [PW-1:0]     ptr_left;
  logic [PW-1:0]     ptr_right;
  logic [PW-1:0]     ptr_step;
  logic              is_move;

  // combinational results of the compute step
  logic [CELL_W-1:0] cell_calc;
  logic [2*CELL_W-1:0] product;
  logic              div_go;
  logic              commit;
  logic              clr_last;
  logic              accept;
  logic [VAL_W-1:0]  oval_calc;

  // divider handshake
  logic              div_start;
  logic              div_done;
  logic [CELL_W-1:0] quotient;

  assign ptr_left  = (ptr == '0) ? PW'(TAPE_CELLS - 1) : ptr - 1'b1;
  assign ptr_right = (ptr == PW'(TAPE_CELLS - 1)) ? '0 : ptr + 1'b1;
  assign is_move   = (act_q == ACT_RIGHT) || (act_q == ACT_LEFT) || (act_q == ACT_HOME);
  assign clr_last  = (clr_addr == PW'(TAPE_CELLS - 1));
  assign accept    = in_valid && in_ready;
  assign product   = ram_rdata * lft_q;
  assign div_go    = (act_q == ACT_DIV) && (lft_q != '0);

  always_comb begin
    unique case (act_q)
      ACT_RIGHT: ptr_step = ptr_right;
      ACT_LEFT:  ptr_step = ptr_left;
      ACT_HOME:  ptr_step = '0;
      default:   ptr_step = ptr;
    endcase
  end

  // new cell value; the current cell is on ram_rdata in S_CUR
  always_comb begin
    unique case (act_q)
      ACT_READ:     cell_calc = rd_q;
      ACT_COPYLEFT: cell_calc = lft_q;
      ACT_CLEAR:    cell_calc = '0;
      ACT_LOAD:     cell_calc = svar[CELL_W-1:0];
      ACT_MUL:      cell_calc = product[CELL_W-1:0];
      ACT_INC:      cell_calc = ram_rdata + 1'b1;
      ACT_DEC:      cell_calc = (ram_rdata == '0) ? '0 : ram_rdata - 1'b1;
      default:      cell_calc = ram_rdata;
    endcase
  end

  always_comb begin
    unique case (act_q)
      ACT_WRITE:    oval_calc = VAL_W'(cur_q);
      ACT_PRINTVAR: oval_calc = svar;
      default:      oval_calc = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_LEFT;
      S_LEFT:  state_next = S_CUR;
      S_CUR: begin
        priority if (div_go) state_next = S_DIV;
        else if (is_move)    state_next = S_MOVE;
        else                 state_next = S_DONE;
      end
      S_DIV:   if (div_done) state_next = S_DONE;
      S_MOVE:  state_next = S_DONE;
      S_DONE:  if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    commit    = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = cell_new_q;
    ram_raddr = ptr;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = ptr_left;
      end
      S_LEFT:  ram_raddr = ptr;
      S_CUR: begin
        ram_raddr = ptr_step;
        div_start = div_go;
      end
      S_DONE: begin
        commit = !result_valid || result_ready;
        ram_we = commit;
      end
      default: ;
    endcase
  end

  tme_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tme_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ram_rdata),
    .divisor  (lft_q),
    .done     (div_done),
    .quotient (quotient)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      ptr          <= '0;
      svar         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (commit) begin
        result_valid <= 1'b1;
        ptr          <= ptr_step;
        unique case (act_q)
          ACT_SAVE:       svar <= VAL_W'(cur_q);
          ACT_VARFROMPTR: svar <= VAL_W'(ptr);
          default:        ;
        endcase
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q <= action_t'(action);
      rd_q  <= read_value;
    end
    if (state == S_LEFT) begin
      lft_q <= ram_rdata;
    end
    if (state == S_CUR) begin
      cur_q      <= ram_rdata;
      cell_new_q <= cell_calc;
      zero_q     <= (cell_calc == '0);
      derr_q     <= (act_q == ACT_DIV) && (lft_q == '0);
    end
    if (state == S_DIV && div_done) begin
      cell_new_q <= quotient;
      zero_q     <= (quotient == '0);
    end
    if (state == S_MOVE) begin
      zero_q <= (ram_rdata == '0);
    end
    if (commit) begin
      out_value    <= oval_calc;
      out_valid    <= (act_q == ACT_WRITE) || (act_q == ACT_PRINTVAR);
      cell_is_zero <= zero_q;
      div_error    <= derr_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tme_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "tape_machine_executor_macros.svh"

module tme_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       result_valid,
  input wire logic                       result_ready,
  input wire logic [tme_pkg::VAL_W-1:0]  out_value,
  input wire logic                       out_valid,
  input wire logic                       cell_is_zero,
  input wire logic                       div_error
);

  // one item at a time: the sequencer leaves idle right after an accept
  `TME_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted twice")

  // silent results carry a zero value
  `TME_ASSERT_IMP(a_quiet_value, result_valid && !out_valid, out_value == '0, "stray out_value")

  // a failed divide never prints
  `TME_ASSERT_IMP(a_div_quiet, result_valid && div_error, !out_valid, "div_error with output")

  // stalled result holds
  `TME_ASSERT_NXT(a_result_hold, result_valid && !result_ready,
                  result_valid && $stable(out_value) && $stable(cell_is_zero),
                  "result dropped while stalled")

endmodule

bind tape_machine_executor tme_checker u_tme_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .out_value    (out_value),
  .out_valid    (out_valid),
  .cell_is_zero (cell_is_zero),
  .div_error    (div_error)
);

`default_nettype wire
